### hw/rtl/rrqs_pkg.sv
// ----------------------------------------------------------------------------
// Round-robin quantum scheduler package
// Shared widths, operation and status codes, and the controller state type.
// ----------------------------------------------------------------------------
package rrqs_pkg;

	localparam int TAG_W     = 8;
	localparam int REM_W     = 16;
	localparam int QUANTUM_W = 16;
	localparam int STATUS_W  = 2;

	localparam logic [QUANTUM_W-1:0] QUANTUM_RST = 16'd10;

	localparam logic FUNC_ADD      = 1'b0;
	localparam logic FUNC_DISPATCH = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_ADDED      = 2'd0,
		ST_FULL       = 2'd1,
		ST_DISPATCHED = 2'd2,
		ST_EMPTY      = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_APOP,
		S_AWR,
		S_ALNK,
		S_DRD,
		S_DLNK,
		S_DFREE,
		S_RESP
	} ctrl_state_t;

	typedef struct packed {
		logic    take;
		logic    alloc_free;
		logic    alloc_fresh;
		logic    pop_free;
		logic    add_write;
		logic    add_link;
		logic    disp_read;
		logic    disp_calc;
		logic    disp_link;
		logic    disp_free;
		logic    load_out;
		status_t out_status;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic free_avail;
		logic finished;
	} sts_t;

endpackage

### hw/rtl/rrqs_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one scheduler operation per transfer.
// ----------------------------------------------------------------------------
interface rrqs_req_if
	import rrqs_pkg::*;
;
	logic             valid;
	logic             ready;
	logic             func;
	logic [TAG_W-1:0] task_tag;
	logic [REM_W-1:0] burst;

	modport source (output valid, output func, output task_tag, output burst, input ready);
	modport sink (input valid, input func, input task_tag, input burst, output ready);
endinterface

### hw/rtl/rrqs_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one scheduler result per transfer.
// ----------------------------------------------------------------------------
interface rrqs_rsp_if
	import rrqs_pkg::*;
;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [TAG_W-1:0]    granted_tag;
	logic [REM_W-1:0]    slice;
	logic                finished;

	modport source (output valid, output status, output granted_tag, output slice,
		output finished, input ready);
	modport sink (input valid, input status, input granted_tag, input slice,
		input finished, output ready);
endinterface

### hw/rtl/rrqs_ctrl.sv
// ----------------------------------------------------------------------------
// Scheduler controller
// Sequences the table accesses of one operation and owns the handshakes.
// ----------------------------------------------------------------------------
module rrqs_ctrl
	import rrqs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_func,
	output logic req_ready,
	output logic rsp_valid,
	input  logic rsp_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	ctrl_state_t state_q, state_nxt;
	status_t     status_q, status_nxt;
	logic        rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			status_q    <= ST_ADDED;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q  <= state_nxt;
			status_q <= status_nxt;
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nxt      = state_q;
		status_nxt     = status_q;
		cmd            = '0;
		cmd.out_status = status_q;
		req_ready      = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.take = 1'b1;
					if (req_func == FUNC_ADD) begin
						if (sts.full) begin
							status_nxt = ST_FULL;
							state_nxt  = S_RESP;
						end else if (sts.free_avail) begin
							status_nxt     = ST_ADDED;
							cmd.alloc_free = 1'b1;
							state_nxt      = S_APOP;
						end else begin
							status_nxt      = ST_ADDED;
							cmd.alloc_fresh = 1'b1;
							state_nxt       = S_AWR;
						end
					end else begin
						if (sts.empty) begin
							status_nxt = ST_EMPTY;
							state_nxt  = S_RESP;
						end else begin
							status_nxt    = ST_DISPATCHED;
							cmd.disp_read = 1'b1;
							state_nxt     = S_DRD;
						end
					end
				end
			end
			S_APOP: begin
				cmd.pop_free = 1'b1;
				state_nxt    = S_AWR;
			end
			S_AWR: begin
				cmd.add_write = 1'b1;
				state_nxt     = S_ALNK;
			end
			S_ALNK: begin
				cmd.add_link = 1'b1;
				state_nxt    = S_RESP;
			end
			S_DRD: begin
				cmd.disp_calc = 1'b1;
				state_nxt     = S_DLNK;
			end
			S_DLNK: begin
				cmd.disp_link = 1'b1;
				state_nxt     = sts.finished ? S_DFREE : S_RESP;
			end
			S_DFREE: begin
				cmd.disp_free = 1'b1;
				state_nxt     = S_RESP;
			end
			S_RESP: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.load_out = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;

endmodule

### hw/rtl/rrqs_dpath.sv
// ----------------------------------------------------------------------------
// Scheduler datapath
// Task table memories, list pointers, free-slot stack, slice arithmetic and
// the response register.
// ----------------------------------------------------------------------------
module rrqs_dpath
	import rrqs_pkg::*;
#(
	parameter int MAX_TASKS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [QUANTUM_W-1:0] cfg_wdata,
	input  logic [TAG_W-1:0]     req_tag,
	input  logic [REM_W-1:0]     req_burst,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	output logic [STATUS_W-1:0]  rsp_status,
	output logic [TAG_W-1:0]     rsp_tag,
	output logic [REM_W-1:0]     rsp_slice,
	output logic                 rsp_finished
);

	localparam int SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CW = $clog2(MAX_TASKS + 1);
	localparam int DW = TAG_W + REM_W;

	logic [DW-1:0] data_mem [MAX_TASKS];
	logic [SW-1:0] link_mem [MAX_TASKS];

	logic [DW-1:0] data_rd_q;
	logic [SW-1:0] link_rd_q;

	logic [QUANTUM_W-1:0] quantum_q;
	logic [SW-1:0]        head_q, tail_q, cur_q, pred_q, free_top_q;
	logic [CW-1:0]        count_q, fresh_q;

	logic [TAG_W-1:0] tag_q, gtag_q;
	logic [REM_W-1:0] burst_q, slice_q;
	logic [SW-1:0]    slot_q, nxt_q;
	logic             fin_q;

	logic [STATUS_W-1:0] rsp_status_q;
	logic [TAG_W-1:0]    rsp_tag_q;
	logic [REM_W-1:0]    rsp_slice_q;
	logic                rsp_fin_q;

	logic [TAG_W-1:0] rd_tag;
	logic [REM_W-1:0] rd_rem, slice_c, rem_new;

	logic          lk_we, d_we;
	logic [SW-1:0] lk_wa, lk_wd, lk_ra, d_wa;
	logic [DW-1:0] d_wd;

	assign rd_tag  = data_rd_q[DW-1:REM_W];
	assign rd_rem  = data_rd_q[REM_W-1:0];
	assign slice_c = (quantum_q < rd_rem) ? quantum_q : rd_rem;
	assign rem_new = rd_rem - slice_c;

	assign sts.full       = (count_q == CW'(MAX_TASKS));
	assign sts.empty      = (count_q == '0);
	assign sts.free_avail = (fresh_q > count_q);
	assign sts.finished   = fin_q;

	assign lk_ra = cmd.alloc_free ? free_top_q : cur_q;

	always_comb begin
		lk_we = 1'b0;
		lk_wa = slot_q;
		lk_wd = head_q;
		if (cmd.add_write) begin
			lk_we = 1'b1;
			lk_wa = slot_q;
			lk_wd = sts.empty ? slot_q : head_q;
		end else if (cmd.add_link) begin
			lk_we = !sts.empty;
			lk_wa = tail_q;
			lk_wd = slot_q;
		end else if (cmd.disp_link) begin
			lk_we = fin_q;
			lk_wa = pred_q;
			lk_wd = nxt_q;
		end else if (cmd.disp_free) begin
			lk_we = 1'b1;
			lk_wa = cur_q;
			lk_wd = free_top_q;
		end
	end

	always_comb begin
		d_we = cmd.add_write | cmd.disp_calc;
		d_wa = cmd.add_write ? slot_q : cur_q;
		d_wd = cmd.add_write ? {tag_q, burst_q} : {rd_tag, rem_new};
	end

	always_ff @(posedge clk) begin
		if (lk_we) begin
			link_mem[lk_wa] <= lk_wd;
		end
		if (cmd.alloc_free || cmd.disp_read) begin
			link_rd_q <= link_mem[lk_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (d_we) begin
			data_mem[d_wa] <= d_wd;
		end
		if (cmd.disp_read) begin
			data_rd_q <= data_mem[cur_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q  <= QUANTUM_RST;
			head_q     <= '0;
			tail_q     <= '0;
			cur_q      <= '0;
			pred_q     <= '0;
			free_top_q <= '0;
			count_q    <= '0;
			fresh_q    <= '0;
		end else begin
			if (cfg_we) begin
				quantum_q <= cfg_wdata;
			end
			if (cmd.alloc_fresh) begin
				fresh_q <= fresh_q + CW'(1);
			end
			if (cmd.pop_free) begin
				free_top_q <= link_rd_q;
			end
			if (cmd.add_link) begin
				count_q <= count_q + CW'(1);
				if (sts.empty) begin
					head_q <= slot_q;
					tail_q <= slot_q;
					cur_q  <= slot_q;
					pred_q <= slot_q;
				end else begin
					if (pred_q == tail_q) begin
						pred_q <= slot_q;
					end
					tail_q <= slot_q;
				end
			end
			if (cmd.disp_link && !fin_q) begin
				pred_q <= cur_q;
				cur_q  <= nxt_q;
			end
			if (cmd.disp_free) begin
				free_top_q <= cur_q;
				count_q    <= count_q - CW'(1);
				cur_q      <= nxt_q;
				if (cur_q == head_q) begin
					head_q <= nxt_q;
				end
				if (cur_q == tail_q) begin
					tail_q <= pred_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			tag_q   <= req_tag;
			burst_q <= req_burst;
		end
		if (cmd.alloc_free) begin
			slot_q <= free_top_q;
		end else if (cmd.alloc_fresh) begin
			slot_q <= fresh_q[SW-1:0];
		end
		if (cmd.disp_calc) begin
			gtag_q  <= rd_tag;
			slice_q <= slice_c;
			nxt_q   <= link_rd_q;
			fin_q   <= (rem_new == '0);
		end
		if (cmd.load_out) begin
			rsp_status_q <= cmd.out_status;
			if (cmd.out_status == ST_DISPATCHED) begin
				rsp_tag_q   <= gtag_q;
				rsp_slice_q <= slice_q;
				rsp_fin_q   <= fin_q;
			end else begin
				rsp_tag_q   <= '0;
				rsp_slice_q <= '0;
				rsp_fin_q   <= 1'b0;
			end
		end
	end

	assign rsp_status   = rsp_status_q;
	assign rsp_tag      = rsp_tag_q;
	assign rsp_slice    = rsp_slice_q;
	assign rsp_finished = rsp_fin_q;

endmodule

### hw/rtl/round_robin_quantum_scheduler.sv
// ----------------------------------------------------------------------------
// Round-robin quantum scheduler
// Keeps an ordered ring of tasks and grants each a bounded time slice in turn.
// ----------------------------------------------------------------------------
// The req channel carries one operation per transfer: func add appends a task
// with its tag and burst at the tail of the ring, func dispatch grants the task
// at the cursor a slice of min(quantum, remaining) and moves the cursor on.
// Every request yields exactly one transfer on the rsp channel with a status,
// the granted tag, the slice and a finished flag for a task that ran out.
// The user must load the quantum register through cfg_we and cfg_wdata only
// while idle; the block itself does not enforce this. One operation is in
// flight at a time. An add runs the free-slot pop (when a freed slot is
// reused), table write, link and response steps; a dispatch runs the table
// read, link, free (when the task finishes) and response steps; a refused add
// or empty dispatch goes straight to the response step, which loads the
// response register; the next request can be taken in the cycle after it.
// The response register lets a new request be taken while the previous
// response still waits. If the receiver stalls, the sequencer holds in its
// response step until the register is free.
// Reset empties the ring and sets the quantum to 10; the table memories need
// no clearing pass.
// ----------------------------------------------------------------------------
module round_robin_quantum_scheduler
	import rrqs_pkg::*;
#(
	parameter int MAX_TASKS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	rrqs_req_if.sink             req,
	rrqs_rsp_if.source           rsp,
	input  logic                 cfg_we,
	input  logic [QUANTUM_W-1:0] cfg_wdata
);

	cmd_t cmd;
	sts_t sts;

	rrqs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_func  (req.func),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rrqs_dpath #(
		.MAX_TASKS (MAX_TASKS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.req_tag      (req.task_tag),
		.req_burst    (req.burst),
		.cmd          (cmd),
		.sts          (sts),
		.rsp_status   (rsp.status),
		.rsp_tag      (rsp.granted_tag),
		.rsp_slice    (rsp.slice),
		.rsp_finished (rsp.finished)
	);

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken while an operation is in flight");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !rsp.valid || rsp.ready)
		else $error("response register loaded over a pending response");

	a_idle_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != ST_DISPATCHED |->
		rsp.granted_tag == '0 && rsp.slice == '0 && !rsp.finished)
		else $error("non-dispatch response carries grant fields");

	a_full_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		sts.full |-> !sts.empty && !sts.free_avail)
		else $error("task count inconsistent with free slot tracking");

endmodule

### bench/rrqs_sched_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler grant checker
// Watches the request, response and quantum ports of the scheduler and keeps
// its own copy of the task ring. Every request transfer yields a predicted
// grant, and every response transfer is compared field by field with the
// oldest one still waiting.
// ----------------------------------------------------------------------------
module rrqs_sched_checker
	import rrqs_pkg::*;
#(
	parameter int MAX_TASKS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	rrqs_req_if                  req,
	rrqs_rsp_if                  rsp,
	input  logic                 cfg_we,
	input  logic [QUANTUM_W-1:0] cfg_wdata,
	output int                   fail_count,
	output int                   pending,
	output int                   n_added,
	output int                   n_refused,
	output int                   n_granted,
	output int                   n_finished,
	output int                   n_idle
);

	localparam int SLOT_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

	typedef logic [SLOT_W-1:0] slot_t;

	typedef struct packed {
		status_t          status;
		logic [TAG_W-1:0] tag;
		logic [REM_W-1:0] slice;
		logic             finished;
	} grant_t;

	logic [TAG_W-1:0]     ring_tag [MAX_TASKS];
	logic [REM_W-1:0]     ring_left[MAX_TASKS];
	slot_t                ring_next[MAX_TASKS];
	logic [MAX_TASKS-1:0] ring_busy;
	slot_t                ring_head;
	slot_t                ring_tail;
	slot_t                ring_cur;
	slot_t                ring_prev;
	int                   ring_count;
	logic [QUANTUM_W-1:0] quantum_now;
	grant_t               grants_due[$];
	int                   n_results;

	function automatic grant_t next_grant(input logic f, input logic [TAG_W-1:0] t,
		input logic [REM_W-1:0] b);
		grant_t           g;
		slot_t            s;
		slot_t            cur;
		slot_t            prv;
		slot_t            nxt;
		logic             found;
		logic [REM_W-1:0] left;
		g = '0;
		s = '0;
		found = 1'b0;
		if (f == FUNC_ADD) begin
			for (int i = 0; i < MAX_TASKS; i++) begin
				if (!ring_busy[i] && !found) begin
					s = slot_t'(i);
					found = 1'b1;
				end
			end
			if (ring_count >= MAX_TASKS || !found) begin
				g.status = ST_FULL;
			end else begin
				ring_busy[s] = 1'b1;
				ring_tag[s] = t;
				ring_left[s] = b;
				if (ring_count == 0) begin
					ring_head = s;
					ring_tail = s;
					ring_cur = s;
					ring_prev = s;
					ring_next[s] = s;
				end else begin
					ring_next[ring_tail] = s;
					ring_next[s] = ring_head;
					if (ring_prev == ring_tail) begin
						ring_prev = s;
					end
					ring_tail = s;
				end
				ring_count++;
				g.status = ST_ADDED;
			end
		end else if (ring_count == 0) begin
			g.status = ST_EMPTY;
		end else begin
			cur = ring_cur;
			prv = ring_prev;
			nxt = ring_next[cur];
			left = ring_left[cur];
			g.slice = (quantum_now < left) ? quantum_now : left;
			g.tag = ring_tag[cur];
			g.status = ST_DISPATCHED;
			left = left - g.slice;
			ring_left[cur] = left;
			if (left == '0) begin
				g.finished = 1'b1;
				ring_busy[cur] = 1'b0;
				ring_count--;
				if (ring_count == 0) begin
					ring_head = '0;
					ring_tail = '0;
					ring_cur = '0;
					ring_prev = '0;
				end else begin
					ring_next[prv] = nxt;
					if (cur == ring_head) begin
						ring_head = nxt;
					end
					if (cur == ring_tail) begin
						ring_tail = prv;
					end
					ring_cur = nxt;
				end
			end else begin
				ring_prev = cur;
				ring_cur = nxt;
			end
		end
		return g;
	endfunction

	task automatic flag_field(input string what, input logic [31:0] want,
		input logic [31:0] got);
		fail_count++;
		if (fail_count <= 10) begin
			$display("mismatch in %s of result %0d: expected 0x%0h, got 0x%0h",
				what, n_results, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		grant_t got;
		grant_t want;
		if (!arst_n) begin
			ring_busy = '0;
			ring_head = '0;
			ring_tail = '0;
			ring_cur = '0;
			ring_prev = '0;
			ring_count = 0;
			quantum_now = QUANTUM_RST;
			grants_due.delete();
			n_results = 0;
			fail_count = 0;
			n_added = 0;
			n_refused = 0;
			n_granted = 0;
			n_finished = 0;
			n_idle = 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				quantum_now = cfg_wdata;
			end
			if (rsp.valid && rsp.ready) begin
				got.status = status_t'(rsp.status);
				got.tag = rsp.granted_tag;
				got.slice = rsp.slice;
				got.finished = rsp.finished;
				if (grants_due.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("result %0d arrived with no request outstanding: status %0h",
							n_results, rsp.status);
					end
				end else begin
					want = grants_due.pop_front();
					if (got.status !== want.status) begin
						flag_field("status", 32'(want.status), 32'(rsp.status));
					end
					if (got.tag !== want.tag) begin
						flag_field("granted_tag", 32'(want.tag), 32'(got.tag));
					end
					if (got.slice !== want.slice) begin
						flag_field("slice", 32'(want.slice), 32'(got.slice));
					end
					if (got.finished !== want.finished) begin
						flag_field("finished", 32'(want.finished), 32'(got.finished));
					end
				end
				n_results++;
			end
			if (req.valid && req.ready) begin
				want = next_grant(req.func, req.task_tag, req.burst);
				grants_due.push_back(want);
				case (want.status)
					ST_ADDED:      n_added++;
					ST_FULL:       n_refused++;
					ST_DISPATCHED: n_granted++;
					ST_EMPTY:      n_idle++;
					default:       ;
				endcase
				if (want.finished) begin
					n_finished++;
				end
			end
			pending <= grants_due.size();
		end
	end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round-robin quantum scheduler testbench
// Drives add and dispatch requests with random gaps and response stalls,
// changes the quantum between phases while the scheduler is idle, and lets
// the grant checker predict and compare every response.
// ----------------------------------------------------------------------------
module testbench;
	import rrqs_pkg::*;

	localparam int     MAX_TASKS       = 16;
	localparam int     RESET_CYCLES    = 12;
	localparam int     SETTLE_CYCLES   = 8;
	localparam int     RSP_HOLD_CYCLES = 300;
	localparam int     PHASES          = 8;
	localparam int     ITEMS_PER_PHASE = 100;
	localparam int     CYCLE_LIMIT     = 1000000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we;
	logic [QUANTUM_W-1:0] cfg_wdata;

	int fail_count;
	int pending;
	int n_added;
	int n_refused;
	int n_granted;
	int n_finished;
	int n_idle;
	int cycle_count = 0;
	int items_sent = 0;
	int quantum_writes = 0;
	bit hold_rsp = 1'b0;
	bit no_idle = 1'b0;

	rrqs_req_if req_ch ();
	rrqs_rsp_if rsp_ch ();

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	round_robin_quantum_scheduler #(
		.MAX_TASKS(MAX_TASKS)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	rrqs_sched_checker #(
		.MAX_TASKS(MAX_TASKS)
	) grant_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending),
		.n_added    (n_added),
		.n_refused  (n_refused),
		.n_granted  (n_granted),
		.n_finished (n_finished),
		.n_idle     (n_idle)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("run stopped after %0d cycles with %0d results outstanding",
				cycle_count, pending);
			$display("status: fail");
			$finish;
		end
	end

	function automatic int idle_len();
		int r;
		if (no_idle) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 96) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 80);
	endfunction

	function automatic logic [REM_W-1:0] pick_burst();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) begin
			return '0;
		end else if (r == 1) begin
			return '1;
		end else if (r == 2) begin
			return REM_W'($urandom_range(0, 65535));
		end
		return REM_W'($urandom_range(1, 48));
	endfunction

	task automatic push_request(input logic f, input logic [TAG_W-1:0] t,
		input logic [REM_W-1:0] b);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.func <= f;
		req_ch.task_tag <= t;
		req_ch.burst <= b;
		@(posedge clk);
		while (req_ch.ready !== 1'b1) @(posedge clk);
		items_sent++;
	endtask

	task automatic dispatch_next();
		push_request(FUNC_DISPATCH, TAG_W'($urandom), REM_W'($urandom));
	endtask

	task automatic drain_results();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_quantum(input logic [QUANTUM_W-1:0] q);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= q;
		@(posedge clk);
		cfg_we <= 1'b0;
		quantum_writes++;
	endtask

	initial begin : response_side
		int stall;
		stall = 0;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_rsp) begin
				rsp_ch.ready <= 1'b0;
				repeat (RSP_HOLD_CYCLES) @(posedge clk);
				hold_rsp = 1'b0;
			end else if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				stall--;
			end else if (!no_idle && $urandom_range(0, 99) < 30) begin
				stall = idle_len();
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		int                   add_pct;
		logic [QUANTUM_W-1:0] q;
		req_ch.valid <= 1'b0;
		req_ch.func <= FUNC_ADD;
		req_ch.task_tag <= '0;
		req_ch.burst <= '0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset quantum of 10 is in force for the opening sequence.
		push_request(FUNC_DISPATCH, 8'hFF, 16'hFFFF);
		push_request(FUNC_ADD, 8'h00, 16'h0000);
		push_request(FUNC_ADD, 8'hFF, 16'hFFFF);
		push_request(FUNC_ADD, 8'hA5, 16'd15);
		repeat (3) dispatch_next();
		// The cursor is back at the head, so this task must wait its turn.
		push_request(FUNC_ADD, 8'h5A, 16'd10);
		repeat (3) dispatch_next();
		for (int i = 0; i < MAX_TASKS - 1; i++) begin
			push_request(FUNC_ADD, TAG_W'(i * 17 + 3), REM_W'(i + 1));
		end
		push_request(FUNC_ADD, 8'h3C, 16'h8000);
		load_quantum('0);
		repeat (2) dispatch_next();
		load_quantum('1);
		repeat (2) dispatch_next();

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0:       q = 16'd1;
				1:       q = QUANTUM_W'($urandom_range(2, 16));
				2:       q = '0;
				3:       q = QUANTUM_W'($urandom_range(1, 65535));
				4:       q = 16'd10;
				5:       q = '1;
				6:       q = QUANTUM_W'($urandom_range(1, 40));
				default: q = 16'd3;
			endcase
			load_quantum(q);
			no_idle = (phase == 4);
			if (phase == 1) begin
				hold_rsp = 1'b1;
			end
			add_pct = 50;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (phase == 3 && n == ITEMS_PER_PHASE / 2) begin
					drain_results();
				end
				if (n % 20 == 0) begin
					case ($urandom_range(0, 2))
						0:       add_pct = 85;
						1:       add_pct = 50;
						default: add_pct = 20;
					endcase
				end
				if ($urandom_range(0, 99) < add_pct) begin
					push_request(FUNC_ADD, TAG_W'($urandom), pick_burst());
				end else begin
					dispatch_next();
				end
			end
		end
		no_idle = 1'b0;
		drain_results();

		$display("covered %0d requests under %0d quantum settings: %0d adds, %0d refused as full",
			items_sent, quantum_writes + 1, n_added, n_refused);
		$display("%0d slices granted, %0d tasks completed, %0d dispatches on an empty ring",
			n_granted, n_finished, n_idle);
		if (fail_count == 0 && pending == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

### round_robin_quantum_scheduler.f
hw/rtl/rrqs_pkg.sv
hw/rtl/rrqs_req_if.sv
hw/rtl/rrqs_rsp_if.sv
hw/rtl/rrqs_ctrl.sv
hw/rtl/rrqs_dpath.sv
hw/rtl/round_robin_quantum_scheduler.sv
bench/rrqs_sched_checker.sv
bench/testbench.sv
